/* hw/rtl/bpe_pkg.sv */
// Shared types and constants for the Bezier point evaluator.
package bpe_pkg;

  // Default sizes of the control point store.
  localparam int MaxPointsDefault  = 8;
  localparam int CoordWidthDefault = 32;

  // Fixed-point constants: 1.0 in Q16.16, and t = 1.0 in Q1.16.
  localparam int OneQ16     = 65536;
  localparam int FracBits   = 16;
  localparam int ParamWidth = 17;

  // Configuration register width and reset value.
  localparam int CountWidth = 4;
  localparam logic [CountWidth-1:0] CountReset = 4'd4;

  // Command codes.
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdEval = 1'b1;

  // Input transaction payload.
  typedef struct packed {
    logic                  command;
    logic [2:0]            point_index;
    logic signed [31:0]    point_x;
    logic signed [31:0]    point_y;
    logic [ParamWidth-1:0] curve_param;
  } bpe_cmd_t;

  // Result transaction payload.
  typedef struct packed {
    logic signed [31:0] curve_x;
    logic signed [31:0] curve_y;
  } bpe_res_t;

endpackage

/* hw/rtl/bezier_point_evaluator.sv */
// Bezier curve point evaluator: control point store and de Casteljau sequencer.
//
//  Channel  Signals                        Direction  Contents
//  cmd      cmd_valid, cmd_ready, cmd      in         load a point, or evaluate at t
//  res      res_valid, res_ready, res      out        curve point (x, y) at t
//  cfg      cfg_we, cfg_wdata              in         point_count register
//
// A load transaction is stored when it is accepted. An evaluate transaction over n
// control points runs n*(n-1)/2 interpolation steps before the result is offered,
// each through the difference, x product, y product and update states on the
// single shared multiplier. cmd_ready is low while a curve is evaluated, and
// the block waits to hand over a result while the previous one is not yet taken.
// Reset (rst, synchronous) loads the default four-point curve and point_count = 4.
module bezier_point_evaluator
  import bpe_pkg::*;
#(
  parameter int MAX_POINTS  = MaxPointsDefault,
  parameter int COORD_WIDTH = CoordWidthDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  bpe_cmd_t              cmd,
  output logic                  res_valid,
  input  logic                  res_ready,
  output bpe_res_t              res,
  input  logic                  cfg_we,
  input  logic [CountWidth-1:0] cfg_wdata
);

  localparam int IdxW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int DiffW = COORD_WIDTH + 1;
  localparam int TW    = ParamWidth + 1;
  localparam int ProdW = DiffW + TW;
  localparam int SatW  = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
  localparam int OutW  = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

  localparam logic signed [SatW-1:0] CoordMax =
    {{(SatW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SatW-1:0] CoordMin = ~CoordMax;
  localparam logic signed [SatW-1:0] OutMax =
    {{(SatW-OutW+1){1'b0}}, {(OutW-1){1'b1}}};
  localparam logic signed [SatW-1:0] OutMin = ~OutMax;
  localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(OneQ16 / 2);
  localparam logic signed [COORD_WIDTH-1:0] CoordOne = COORD_WIDTH'(OneQ16);
  localparam logic [ParamWidth-1:0] ParamOne = ParamWidth'(OneQ16);

  typedef enum logic [2:0] {
    StIdle,
    StSub,
    StMulX,
    StMulY,
    StAdd,
    StDone
  } state_t;

  state_t state;

  // Control point store and the working queues of the interpolation.
  logic signed [COORD_WIDTH-1:0] ctrl_x_store [MAX_POINTS];
  logic signed [COORD_WIDTH-1:0] ctrl_y_store [MAX_POINTS];
  logic signed [COORD_WIDTH-1:0] work_x [MAX_POINTS];
  logic signed [COORD_WIDTH-1:0] work_y [MAX_POINTS];
  logic signed [COORD_WIDTH-1:0] work_x_next [MAX_POINTS];
  logic signed [COORD_WIDTH-1:0] work_y_next [MAX_POINTS];

  logic [CountWidth-1:0]   point_count;
  logic [ParamWidth-1:0]   t_param;
  logic [IdxW-1:0]         level;
  logic [IdxW-1:0]         step;
  logic signed [DiffW-1:0] diff_x;
  logic signed [DiffW-1:0] diff_y;
  logic signed [ProdW-1:0] prod_x;
  logic signed [ProdW-1:0] prod_y;

  // Load path: sign-extend the 32-bit coordinate and saturate to the store width.
  logic signed [SatW-1:0]        load_x_ext;
  logic signed [SatW-1:0]        load_y_ext;
  logic signed [COORD_WIDTH-1:0] load_x_sat;
  logic signed [COORD_WIDTH-1:0] load_y_sat;
  logic                          load_hit;
  logic [IdxW-1:0]               load_addr;

  always_comb begin
    load_x_ext = SatW'(cmd.point_x);
    load_y_ext = SatW'(cmd.point_y);
    if (load_x_ext > CoordMax) begin
      load_x_sat = COORD_WIDTH'(CoordMax);
    end else if (load_x_ext < CoordMin) begin
      load_x_sat = COORD_WIDTH'(CoordMin);
    end else begin
      load_x_sat = COORD_WIDTH'(load_x_ext);
    end
    if (load_y_ext > CoordMax) begin
      load_y_sat = COORD_WIDTH'(CoordMax);
    end else if (load_y_ext < CoordMin) begin
      load_y_sat = COORD_WIDTH'(CoordMin);
    end else begin
      load_y_sat = COORD_WIDTH'(load_y_ext);
    end
    load_hit  = (int'(cmd.point_index) < MAX_POINTS);
    load_addr = IdxW'(cmd.point_index);
  end

  // Evaluate setup: limit t to 1.0 and the point count to the range 2 to the store depth.
  logic [ParamWidth-1:0] t_sat;
  logic [IdxW-1:0]       level_init;
  int                    count_eff;

  always_comb begin
    t_sat = (cmd.curve_param > ParamOne) ? ParamOne : cmd.curve_param;
    if (int'(point_count) < 2) begin
      count_eff = 2;
    end else if (int'(point_count) > MAX_POINTS) begin
      count_eff = MAX_POINTS;
    end else begin
      count_eff = int'(point_count);
    end
    level_init = IdxW'(count_eff - 1);
  end

  // Shared multiplier: the x difference in the StMulX state, the y difference in the StMulY state that follows.
  logic signed [DiffW-1:0] mul_op;
  logic signed [TW-1:0]    t_signed;
  logic signed [ProdW-1:0] mul_out;

  always_comb begin
    mul_op   = (state == StMulX) ? diff_x : diff_y;
    t_signed = $signed({1'b0, t_param});
    mul_out  = mul_op * t_signed;
  end

  // Interpolation update: round the product half up, drop the fraction, add to a.
  logic signed [ProdW-1:0]       rnd_x;
  logic signed [ProdW-1:0]       rnd_y;
  logic signed [COORD_WIDTH-1:0] lerp_x;
  logic signed [COORD_WIDTH-1:0] lerp_y;
  logic                          last_step;
  logic [IdxW-1:0]               tail_idx;

  always_comb begin
    rnd_x     = (prod_x + RoundHalf) >>> FracBits;
    rnd_y     = (prod_y + RoundHalf) >>> FracBits;
    lerp_x    = work_x[0] + COORD_WIDTH'(rnd_x);
    lerp_y    = work_y[0] + COORD_WIDTH'(rnd_y);
    last_step = (step == level - IdxW'(1));
    tail_idx  = last_step ? (level - IdxW'(1)) : level;
  end

  // Queue update: pop the head (and the level's last point on its final step),
  // then append the new interpolated point behind the ones of this level.
  always_comb begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (last_step) begin
        work_x_next[i] = work_x[(i + 2 < MAX_POINTS) ? i + 2 : MAX_POINTS - 1];
        work_y_next[i] = work_y[(i + 2 < MAX_POINTS) ? i + 2 : MAX_POINTS - 1];
      end else begin
        work_x_next[i] = work_x[(i + 1 < MAX_POINTS) ? i + 1 : MAX_POINTS - 1];
        work_y_next[i] = work_y[(i + 1 < MAX_POINTS) ? i + 1 : MAX_POINTS - 1];
      end
    end
    work_x_next[tail_idx] = lerp_x;
    work_y_next[tail_idx] = lerp_y;
  end

  // Output saturation to the narrower of the store and port ranges.
  logic signed [SatW-1:0] fin_x_ext;
  logic signed [SatW-1:0] fin_y_ext;
  logic signed [SatW-1:0] fin_x_sat;
  logic signed [SatW-1:0] fin_y_sat;

  always_comb begin
    fin_x_ext = SatW'(work_x[0]);
    fin_y_ext = SatW'(work_y[0]);
    if (fin_x_ext > OutMax) begin
      fin_x_sat = OutMax;
    end else if (fin_x_ext < OutMin) begin
      fin_x_sat = OutMin;
    end else begin
      fin_x_sat = fin_x_ext;
    end
    if (fin_y_ext > OutMax) begin
      fin_y_sat = OutMax;
    end else if (fin_y_ext < OutMin) begin
      fin_y_sat = OutMin;
    end else begin
      fin_y_sat = fin_y_ext;
    end
  end

  assign cmd_ready = (state == StIdle);

  // Sequencer, store, configuration register and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= StIdle;
      res_valid   <= 1'b0;
      point_count <= CountReset;
      for (int i = 0; i < MAX_POINTS; i++) begin
        ctrl_x_store[i] <= (i == 2 || i == 3) ? CoordOne : '0;
        ctrl_y_store[i] <= (i == 1) ? CoordOne : ((i == 2) ? -CoordOne : '0);
      end
    end else begin
      if (cfg_we) begin
        point_count <= cfg_wdata;
      end
      // A result taken while a new one is ready is replaced in the done state.
      if (res_valid && res_ready && state != StDone) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        StIdle: begin
          if (cmd_valid) begin
            if (cmd.command == CmdLoad) begin
              if (load_hit) begin
                ctrl_x_store[load_addr] <= load_x_sat;
                ctrl_y_store[load_addr] <= load_y_sat;
              end
            end else begin
              work_x  <= ctrl_x_store;
              work_y  <= ctrl_y_store;
              t_param <= t_sat;
              level   <= level_init;
              step    <= '0;
              state   <= StSub;
            end
          end
        end
        StSub: begin
          diff_x <= DiffW'(work_x[1]) - DiffW'(work_x[0]);
          diff_y <= DiffW'(work_y[1]) - DiffW'(work_y[0]);
          state  <= StMulX;
        end
        StMulX: begin
          prod_x <= mul_out;
          state  <= StMulY;
        end
        StMulY: begin
          prod_y <= mul_out;
          state  <= StAdd;
        end
        StAdd: begin
          work_x <= work_x_next;
          work_y <= work_y_next;
          if (last_step) begin
            step <= '0;
            if (level == IdxW'(1)) begin
              state <= StDone;
            end else begin
              level <= level - IdxW'(1);
              state <= StSub;
            end
          end else begin
            step  <= step + IdxW'(1);
            state <= StSub;
          end
        end
        StDone: begin
          if (!res_valid || res_ready) begin
            res_valid   <= 1'b1;
            res.curve_x <= fin_x_sat[31:0];
            res.curve_y <= fin_y_sat[31:0];
            state       <= StIdle;
          end
        end
        default: begin
          state <= StIdle;
        end
      endcase
    end
  end

endmodule

/* sim/bezier_point_evaluator_tb.sv */
// Testbench for the Bezier point evaluator: directed and random transactions checked by a scoreboard.
`timescale 1ns / 100ps

module bezier_point_evaluator_tb;
  import bpe_pkg::*;

  localparam int MaxPts      = MaxPointsDefault;
  localparam int StallCycles = 400;
  localparam int SettleCycles = 150;
  localparam longint TimeoutNs = 64'd10_000_000;

  // Scoreboard: keeps its own copy of the control points and the point count,
  // predicts each curve point and compares it with the result transactions.
  class curve_scoreboard;
    longint   x_pts[MaxPts];
    longint   y_pts[MaxPts];
    logic [CountWidth-1:0] count_reg;
    bpe_res_t expected_points[$];
    int       mismatch_count;

    function new();
      for (int i = 0; i < MaxPts; i++) begin
        x_pts[i] = 0;
        y_pts[i] = 0;
      end
      x_pts[2] = OneQ16;
      x_pts[3] = OneQ16;
      y_pts[1] = OneQ16;
      y_pts[2] = -OneQ16;
      count_reg = CountReset;
      mismatch_count = 0;
    endfunction

    function void set_point_count(logic [CountWidth-1:0] value);
      count_reg = value;
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    // One interpolation step, rounded half toward plus infinity.
    function longint lerp_q16(longint a, longint b, longint t);
      return a + (((b - a) * t + 32768) >>> FracBits);
    endfunction

    // De Casteljau reduction over the first n points of one axis.
    function longint casteljau_axis(longint pts[MaxPts], int n, longint t);
      longint work[MaxPts];
      for (int i = 0; i < MaxPts; i++) work[i] = pts[i];
      for (int level = n - 1; level > 0; level--)
        for (int i = 0; i < level; i++) work[i] = lerp_q16(work[i], work[i + 1], t);
      return work[0];
    endfunction

    function logic signed [31:0] saturate32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    // Notes an accepted command: a load updates the store, an evaluate queues a point.
    function void note_command(bpe_cmd_t c);
      longint   t;
      int       n;
      bpe_res_t p;
      if (c.command == CmdLoad) begin
        x_pts[c.point_index] = longint'($signed(c.point_x));
        y_pts[c.point_index] = longint'($signed(c.point_y));
      end else begin
        t = (c.curve_param > OneQ16) ? OneQ16 : c.curve_param;
        n = int'(count_reg);
        if (n < 2) n = 2;
        if (n > MaxPts) n = MaxPts;
        p.curve_x = saturate32(casteljau_axis(x_pts, n, t));
        p.curve_y = saturate32(casteljau_axis(y_pts, n, t));
        expected_points.push_back(p);
      end
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      mismatch_count++;
    endtask

    // Compares one result transaction with the oldest predicted point.
    task check_point(bpe_res_t r);
      bpe_res_t p;
      if (expected_points.size() == 0) begin
        report($sformatf("unexpected result (%0d, %0d)", r.curve_x, r.curve_y));
      end else begin
        p = expected_points.pop_front();
        if (r.curve_x !== p.curve_x)
          report($sformatf("curve_x got %0d expected %0d", r.curve_x, p.curve_x));
        if (r.curve_y !== p.curve_y)
          report($sformatf("curve_y got %0d expected %0d", r.curve_y, p.curve_y));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cmd_valid = 1'b0;
  logic                  cmd_ready;
  bpe_cmd_t              cmd = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  bpe_res_t              res;
  logic                  cfg_we = 1'b0;
  logic [CountWidth-1:0] cfg_wdata = '0;

  curve_scoreboard board = new();
  bit idle_enable = 1'b1;
  bit stall_request = 1'b0;
  int stall_left = 0;

  bezier_point_evaluator i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Watch both channels and hand every transaction to the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && cmd_ready) board.note_command(cmd);
      if (res_valid && res_ready) board.check_point(res);
    end
  end

  // Result receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_left = StallCycles;
        stall_request = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= !(idle_enable && $urandom_range(99) < 28);
      end
    end
  end

  // Offers one command and returns once cmd_ready is seen high after an edge.
  task automatic send_cmd(input bpe_cmd_t c);
    if (idle_enable) begin
      while ($urandom_range(99) < 28) begin
        cmd_valid <= 1'b0;
        @(posedge clk);
      end
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
  endtask

  // Waits until every predicted point has come back.
  task automatic wait_drained();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Writes the point count once the block has gone idle.
  task automatic write_count(input logic [CountWidth-1:0] value);
    wait_drained();
    repeat (10) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_point_count(value);
  endtask

  function automatic bpe_cmd_t make_cmd(logic command, int idx, int x, int y, int t);
    bpe_cmd_t c;
    c.command = command;
    c.point_index = idx[2:0];
    c.point_x = x;
    c.point_y = y;
    c.curve_param = t[ParamWidth-1:0];
    return c;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2, 3: return $urandom;
      default: return int'($urandom_range(0, 1 << 23)) - (1 << 22);
    endcase
  endfunction

  function automatic logic [ParamWidth-1:0] rand_param();
    case ($urandom_range(7))
      0: return '0;
      1: return ParamWidth'(OneQ16);
      2: return ParamWidth'($urandom_range(OneQ16 + 1, (1 << ParamWidth) - 1));
      default: return ParamWidth'($urandom_range(0, OneQ16));
    endcase
  endfunction

  // Random command; ignored fields carry random values too.
  function automatic bpe_cmd_t rand_command(int load_pct);
    bpe_cmd_t c;
    c.command = ($urandom_range(99) < load_pct) ? CmdLoad : CmdEval;
    c.point_index = 3'($urandom_range(MaxPts - 1));
    c.point_x = rand_coord();
    c.point_y = rand_coord();
    c.curve_param = rand_param();
    return c;
  endfunction

  initial begin
    logic [CountWidth-1:0] phase_counts[11];
    phase_counts = '{4'd2, 4'd8, 4'd0, 4'd15, 4'd5, 4'd1, 4'd9, 4'd3, 4'd6, 4'd7, 4'd4};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default curve at the ends, the middle, and parameters above one.
    send_cmd(make_cmd(CmdEval, 0, 0, 0, 0));
    send_cmd(make_cmd(CmdEval, 0, 0, 0, OneQ16));
    send_cmd(make_cmd(CmdEval, 0, 0, 0, OneQ16 / 2));
    send_cmd(make_cmd(CmdEval, 0, 0, 0, OneQ16 + 1));
    send_cmd(make_cmd(CmdEval, 7, -1, -1, (1 << ParamWidth) - 1));

    // Loads of extreme coordinates, with junk in the ignored parameter, and evaluations near the ends and the middle.
    send_cmd(make_cmd(CmdLoad, 0, 32'h7FFFFFFF, 32'h80000000, (1 << ParamWidth) - 1));
    send_cmd(make_cmd(CmdLoad, 1, 32'h80000000, 32'h7FFFFFFF, 0));
    send_cmd(make_cmd(CmdLoad, 2, 32'h7FFFFFFF, 32'h7FFFFFFF, OneQ16));
    send_cmd(make_cmd(CmdLoad, 3, 32'h80000000, 32'h80000000, 12345));
    send_cmd(make_cmd(CmdEval, 0, 0, 0, 1));
    send_cmd(make_cmd(CmdEval, 0, 0, 0, OneQ16 / 2 - 1));
    send_cmd(make_cmd(CmdEval, 0, 0, 0, OneQ16 - 1));
    send_cmd(make_cmd(CmdLoad, 4, -1, 1, 0));
    send_cmd(make_cmd(CmdLoad, 5, 32'h80000000, 0, 0));
    send_cmd(make_cmd(CmdLoad, 6, 0, 32'h7FFFFFFF, 0));
    send_cmd(make_cmd(CmdLoad, 7, 32'h7FFFFFFF, 32'h80000000, 0));

    // Full eight-point curve.
    write_count(4'd8);
    send_cmd(make_cmd(CmdEval, 0, 0, 0, 0));
    send_cmd(make_cmd(CmdEval, 0, 0, 0, OneQ16));
    send_cmd(make_cmd(CmdEval, 0, 0, 0, 21845));
    send_cmd(make_cmd(CmdEval, 0, 0, 0, 40000));

    // Random phases over several point counts, out-of-range ones among them.
    for (int ph = 0; ph < 11; ph++) begin
      write_count(phase_counts[ph]);
      idle_enable = (ph != 2);
      if (ph == 4) stall_request = 1'b1;
      for (int k = 0; k < 102; k++) send_cmd(rand_command((ph == 4) ? 10 : 35));
    end
    idle_enable = 1'b1;

    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (board.mismatch_count == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Safety net against a hung handshake.
  initial begin
    #(TimeoutNs);
    $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/bpe_pkg.sv
hw/rtl/bezier_point_evaluator.sv
sim/bezier_point_evaluator_tb.sv
